### rtl/xks_pkg.sv
// Package for the X9.63 KDF SHA-256 core: round constants, IV, widths.
// No dependencies; imported by x963_kdf_sha256_core.
package xks_pkg;
  localparam int MaxKeyBytes = 128;
  localparam int KeyBytesW = 8;
  localparam int ValidW = 4;
  localparam logic [31:0] MsgBits = 32'd544;
  localparam logic [31:0] PadWord = 32'h8000_0000;

  function automatic logic [31:0] sha_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] sha_iv(input logic [2:0] i);
    logic [31:0] v [8];
    v = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return v[i];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

### rtl/x963_kdf_sha256_core.sv
// X9.63 KDF with SHA-256: key store, one shared SHA-256 round unit, key output.
// Depends on xks_pkg.
//
// Usage:
//  - Load channel: a transfer happens when in_start is high and busy is low.
//    Each transfer writes word in_word_data to slot in_word_index (0-3 secret,
//    4-7 shared info). With in_start_req set, derivation starts after the write.
//  - Config channel: cfg_valid/cfg_ready write key_bytes (reset 64); values
//    above 128 saturate to 128, zero yields no output. Ready while idle.
//  - Result channel: out_strobe marks one key word for exactly one cycle with
//    out_key_word, out_valid_bytes and out_last_word. The receiver cannot stall.
// Sequence: a load without start leaves the core idle. Each 32 key bytes cost
//  one digest: a schedule load state, then two compressions of 64 rounds on the
//  single round unit, each followed by a feed-forward state, then up to four
//  key words, one key word per cycle. Busy stays high throughout a derivation.
// Reset returns the control state to idle and key_bytes to 64; the secret and
//  info stores hold garbage until loaded.
module x963_kdf_sha256_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_start,
  output logic        busy,
  input  logic [2:0]  in_word_index,
  input  logic [63:0] in_word_data,
  input  logic        in_start_req,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_key_bytes,
  output logic        out_strobe,
  output logic [63:0] out_key_word,
  output logic [3:0]  out_valid_bytes,
  output logic        out_last_word
);
  import xks_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ROUND, S_FOLD, S_EMIT} state_t;

  state_t       state_r;
  logic [63:0]  store_r [8];
  logic [7:0]   key_bytes_r;
  logic [7:0]   remain_r;
  logic [31:0]  ctr_r;
  logic         blk_r;
  logic [5:0]   rnd_r;
  logic [1:0]   wsel_r;
  logic [31:0]  w_r [16];
  logic [31:0]  h_r [8];
  logic [31:0]  v_r [8];

  logic         accept;
  logic [31:0]  w_cur, s0, s1, ss1, ss0, ch, mj, t1, t2;
  logic [63:0]  dig;
  logic [63:0]  mask;

  assign accept    = in_start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  // Schedule word and round terms for this round; rolling 16-word window.
  always_comb begin
    s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    w_cur = (rnd_r < 6'd16) ? w_r[0] : (w_r[0] + s0 + w_r[9] + s1);
    ss1 = ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25);
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1  = v_r[7] + ss1 + ch + sha_k(rnd_r) + w_cur;
    ss0 = ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22);
    mj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2  = ss0 + mj;
  end

  always_comb begin
    dig = {h_r[{wsel_r, 1'b0}], h_r[{wsel_r, 1'b1}]};
    if (remain_r >= 8'd8) begin
      mask = '1;
    end else begin
      mask = ~(64'hffff_ffff_ffff_ffff >> {remain_r[2:0], 3'b000});
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store_r[in_word_index] <= in_word_data;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_bytes_r <= 8'd64;
      out_strobe  <= 1'b0;
    end else begin
      // Strobe each key word for exactly one cycle.
      out_strobe <= (state_r == S_EMIT);
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            key_bytes_r <= cfg_key_bytes;
          end
          if (accept && in_start_req) begin
            remain_r <= (key_bytes_r > 8'(MaxKeyBytes)) ? 8'(MaxKeyBytes) : key_bytes_r;
            ctr_r    <= 32'd1;
            state_r  <= (key_bytes_r == 8'd0) ? S_IDLE : S_LOAD;
          end
        end
        S_LOAD: begin
          // Build block one (store is up to date after the load cycle).
          for (int i = 0; i < 4; i++) begin
            w_r[2*i]   <= store_r[i][63:32];
            w_r[2*i+1] <= store_r[i][31:0];
          end
          w_r[8] <= ctr_r;
          for (int i = 0; i < 7; i++) begin
            w_r[9+i] <= (i % 2 == 0) ? store_r[4 + i/2][63:32] : store_r[4 + i/2][31:0];
          end
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= sha_iv(3'(i));
            v_r[i] <= sha_iv(3'(i));
          end
          blk_r   <= 1'b0;
          rnd_r   <= '0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          // Advance the window and one compression round.
          for (int i = 0; i < 15; i++) begin
            w_r[i] <= w_r[i+1];
          end
          w_r[15] <= w_cur;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= h_r[i] + v_r[i];
            v_r[i] <= h_r[i] + v_r[i];
          end
          rnd_r <= '0;
          if (!blk_r) begin
            // Second, padded block.
            for (int i = 2; i < 15; i++) begin
              w_r[i] <= '0;
            end
            w_r[0]  <= store_r[7][31:0];
            w_r[1]  <= PadWord;
            w_r[15] <= MsgBits;
            blk_r   <= 1'b1;
            state_r <= S_ROUND;
          end else begin
            wsel_r  <= '0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_key_word    <= dig & mask;
          out_valid_bytes <= (remain_r >= 8'd8) ? 4'd8 : {1'b0, remain_r[2:0]};
          out_last_word   <= (remain_r <= 8'd8);
          remain_r        <= (remain_r >= 8'd8) ? remain_r - 8'd8 : 8'd0;
          wsel_r          <= wsel_r + 2'd1;
          if (remain_r <= 8'd8) begin
            state_r <= S_IDLE;
          end else if (wsel_r == 2'd3) begin
            ctr_r   <= ctr_r + 32'd1;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cfg_ready) else $error("cfg ready while busy");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_word) |-> !busy || $past(state_r == S_EMIT))
    else $error("last word without end");
  a_strobe_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_EMIT)) else $error("stray strobe");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == 6'd63) |=> state_r == S_FOLD)
    else $error("round count");
`endif
endmodule
